[src/tcpk_pkg.sv]
// Shared types, constants and stage functions of the two-cord plotter kinematics pipeline.
package tcpk_pkg;

  // Opcodes carried in tuser.
  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // Saturation limits.
  localparam logic [16:0] X_MAX   = 17'h07FFF;
  localparam logic [16:0] X_MIN   = 17'h18000;
  localparam logic [16:0] LEN_MAX = 17'h0FFFF;

  // Divider and square root geometry.
  localparam int DVD_W          = 34;
  localparam int DIV_PER_STAGE  = 2;
  localparam int DIV_STAGES     = DVD_W / DIV_PER_STAGE;
  localparam int RAD_W          = 36;
  localparam int ROOT_W         = RAD_W / 2;
  localparam int SREM_W         = ROOT_W + 3;

  // Stage positions.
  localparam int ST_IN      = 0;
  localparam int ST_SQ      = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_DIV0    = 3;
  localparam int ST_POST    = ST_DIV0 + DIV_STAGES;
  localparam int ST_RAD     = ST_POST + 1;
  localparam int ST_SQRT0   = ST_RAD + 1;
  localparam int ST_OUT     = ST_SQRT0 + ROOT_W;
  localparam int NUM_STAGES = ST_OUT + 1;

  // One word in flight; each stage uses the fields it needs.
  typedef struct packed {
    logic               op;
    logic               dz;
    logic               neg;
    logic               neg_rad;
    logic               bad;
    logic [16:0]        a;
    logic [15:0]        b;
    logic [15:0]        d;
    logic [33:0]        asq;
    logic [33:0]        bsq;
    logic [33:0]        csq;
    logic [RAD_W-1:0]   rad1;
    logic [RAD_W-1:0]   rad2;
    logic [DVD_W-1:0]   dvd;
    logic [16:0]        dvs;
    logic [17:0]        rem;
    logic [DVD_W-1:0]   quo;
    logic [16:0]        x;
    logic [15:0]        r2;
    logic [ROOT_W-1:0]  root1;
    logic [ROOT_W-1:0]  root2;
    logic [SREM_W-1:0]  srem1;
    logic [SREM_W-1:0]  srem2;
  } tcpk_item_t;

  // Magnitude of a 17-bit two's complement value.
  function automatic logic [16:0] abs17(logic [16:0] v);
    return v[16] ? 17'(17'd0 - v) : v;
  endfunction

  // Squares of the operands.
  function automatic tcpk_item_t square_stage(tcpk_item_t p);
    tcpk_item_t       r;
    logic [16:0]      al;
    logic [17:0]      diff;
    logic [16:0]      adx;
    logic [16:0]      m;
    r    = p;
    al   = abs17(p.a);
    diff = {2'b00, p.d} - {p.a[16], p.a};
    adx  = diff[17] ? 17'(18'd0 - diff) : diff[16:0];
    m    = (p.op == OP_INVERSE) ? {1'b0, p.d} : adx;
    r.asq = {17'd0, al} * {17'd0, al};
    r.bsq = {18'd0, p.b} * {18'd0, p.b};
    r.csq = {17'd0, m} * {17'd0, m};
    return r;
  endfunction

  // Radicands for the forward direction and the signed numerator for the inverse.
  function automatic tcpk_item_t sum_stage(tcpk_item_t p);
    tcpk_item_t   r;
    logic [35:0]  num;
    logic [35:0]  mag;
    r      = p;
    r.rad1 = {2'b00, p.asq} + {2'b00, p.bsq};
    r.rad2 = {2'b00, p.csq} + {2'b00, p.bsq};
    num    = {2'b00, p.csq} + {2'b00, p.asq} - {2'b00, p.bsq};
    mag    = num[35] ? 36'd0 - num : num;
    r.neg  = num[35];
    r.dvd  = mag[DVD_W-1:0];
    r.dvs  = {p.d, 1'b0};
    r.rem  = '0;
    r.quo  = '0;
    return r;
  endfunction

  // Restoring division, a couple of quotient bits per stage.
  function automatic tcpk_item_t div_stage(tcpk_item_t p);
    tcpk_item_t   r;
    logic [17:0]  t;
    r = p;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      t     = {r.rem[16:0], r.dvd[DVD_W-1]};
      r.dvd = {r.dvd[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, r.dvs}) begin
        r.rem = t - {1'b0, r.dvs};
        r.quo = {r.quo[DVD_W-2:0], 1'b1};
      end else begin
        r.rem = t;
        r.quo = {r.quo[DVD_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // For the inverse direction, clamp x, detect a negative radicand and square the quotient.
  function automatic tcpk_item_t post_stage(tcpk_item_t p);
    tcpk_item_t   r;
    logic [32:0]  aq;
    logic [16:0]  al;
    r  = p;
    aq = p.dz ? 33'd0 : p.quo[32:0];
    al = abs17(p.a);
    if (p.op == OP_INVERSE) begin
      if (!p.neg && aq > 33'd32767) begin
        r.x   = X_MAX;
        r.bad = 1'b1;
      end else if (p.neg && aq > 33'd32768) begin
        r.x   = X_MIN;
        r.bad = 1'b1;
      end else begin
        r.x = p.neg ? 17'(17'd0 - aq[16:0]) : aq[16:0];
      end
      if (p.dz) begin
        r.bad = 1'b1;
      end
      r.neg_rad = aq > {16'd0, al};
      r.bsq     = {17'd0, aq[16:0]} * {17'd0, aq[16:0]};
    end
    return r;
  endfunction

  // Select the inverse radicand and clear the root state.
  function automatic tcpk_item_t rad_stage(tcpk_item_t p);
    tcpk_item_t r;
    r = p;
    if (p.op == OP_INVERSE) begin
      r.rad1 = {2'b00, p.asq - p.bsq};
    end
    r.root1 = '0;
    r.root2 = '0;
    r.srem1 = '0;
    r.srem2 = '0;
    return r;
  endfunction

  // One digit of both square roots.
  function automatic tcpk_item_t sqrt_stage(tcpk_item_t p);
    tcpk_item_t         r;
    logic [SREM_W-1:0]  t;
    logic [SREM_W-1:0]  tr;
    r  = p;
    t  = {p.srem1[SREM_W-3:0], p.rad1[RAD_W-1:RAD_W-2]};
    tr = {1'b0, p.root1, 2'b01};
    if (t >= tr) begin
      r.srem1 = t - tr;
      r.root1 = {p.root1[ROOT_W-2:0], 1'b1};
    end else begin
      r.srem1 = t;
      r.root1 = {p.root1[ROOT_W-2:0], 1'b0};
    end
    t  = {p.srem2[SREM_W-3:0], p.rad2[RAD_W-1:RAD_W-2]};
    tr = {1'b0, p.root2, 2'b01};
    if (t >= tr) begin
      r.srem2 = t - tr;
      r.root2 = {p.root2[ROOT_W-2:0], 1'b1};
    end else begin
      r.srem2 = t;
      r.root2 = {p.root2[ROOT_W-2:0], 1'b0};
    end
    r.rad1 = {p.rad1[RAD_W-3:0], 2'b00};
    r.rad2 = {p.rad2[RAD_W-3:0], 2'b00};
    return r;
  endfunction

  // Saturate the roots and form the result word.
  function automatic tcpk_item_t out_stage(tcpk_item_t p);
    tcpk_item_t r;
    logic       s1;
    logic       s2;
    r  = p;
    s1 = p.root1[ROOT_W-1:16] != '0;
    s2 = p.root2[ROOT_W-1:16] != '0;
    if (p.op == OP_FORWARD) begin
      r.x   = s1 ? LEN_MAX : {1'b0, p.root1[15:0]};
      r.r2  = s2 ? LEN_MAX[15:0] : p.root2[15:0];
      r.bad = s1 | s2;
    end else begin
      r.r2  = p.neg_rad ? 16'd0 : (s1 ? LEN_MAX[15:0] : p.root1[15:0]);
      r.bad = p.bad | p.neg_rad | s1;
    end
    return r;
  endfunction

endpackage

[src/two_cord_plotter_kinematics.sv]
// Top level of the two-cord plotter forward and inverse kinematics pipeline.
// A fully pipelined converter: one word is accepted every cycle unless the output stalls, and
// its result passes through 41 register stages (input register, squares, sums,
// 17 divider stages of two quotient bits, clamp, radicand select, 18 square root stages of
// one root bit, output register) before it is offered on the output. The
// whole pipeline advances whenever the output word is empty or being taken, so a stall
// on the output side holds every stage. Op 0 turns a pen position (x, y) into the two
// cord lengths; op 1 turns two cord lengths into (x, y), using the anchor spacing that
// was last written on the configuration channel (reset value 1600). The tuser flag on
// the output marks a negative radicand, a saturated result or, for op 1, a zero spacing.
module two_cord_plotter_kinematics (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel: anchor spacing.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [16:0] first_in, [32:17] second_in, rest zero
  input  logic        s_axis_tuser,   // [0] op
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [16:0] first_out, [32:17] second_out, rest zero
  output logic        m_axis_tuser    // [0] invalid
);
  import tcpk_pkg::*;

  logic [15:0]  spacing_q;
  logic         adv;
  logic         valid_q [NUM_STAGES];
  tcpk_item_t   pipe_q  [NUM_STAGES];
  tcpk_item_t   pipe_d  [NUM_STAGES];

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= 16'd1600;
    end else if (cfg_valid_i) begin
      spacing_q <= cfg_data_i;
    end
  end

  // The pipeline moves as one when the last stage is free or drained.
  assign adv           = !valid_q[NUM_STAGES-1] || m_axis_tready;
  assign s_axis_tready = adv;

  // Input stage capture.
  always_comb begin
    pipe_d[ST_IN]    = '0;
    pipe_d[ST_IN].op = s_axis_tuser;
    pipe_d[ST_IN].a  = s_axis_tdata[16:0];
    pipe_d[ST_IN].b  = s_axis_tdata[32:17];
    pipe_d[ST_IN].d  = spacing_q;
    pipe_d[ST_IN].dz = spacing_q == 16'd0;
  end

  // Per-stage work.
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
    if (k == ST_SQ) begin : g_sq
      always_comb pipe_d[k] = square_stage(pipe_q[k-1]);
    end else if (k == ST_SUM) begin : g_sum
      always_comb pipe_d[k] = sum_stage(pipe_q[k-1]);
    end else if (k < ST_POST) begin : g_div
      always_comb pipe_d[k] = div_stage(pipe_q[k-1]);
    end else if (k == ST_POST) begin : g_post
      always_comb pipe_d[k] = post_stage(pipe_q[k-1]);
    end else if (k == ST_RAD) begin : g_rad
      always_comb pipe_d[k] = rad_stage(pipe_q[k-1]);
    end else if (k < ST_OUT) begin : g_sqrt
      always_comb pipe_d[k] = sqrt_stage(pipe_q[k-1]);
    end else begin : g_out
      always_comb pipe_d[k] = out_stage(pipe_q[k-1]);
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[ST_IN] <= s_axis_tvalid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
  end

  // Output word.
  assign m_axis_tvalid = valid_q[NUM_STAGES-1];
  assign m_axis_tdata  = {7'd0, pipe_q[NUM_STAGES-1].r2, pipe_q[NUM_STAGES-1].x};
  assign m_axis_tuser  = pipe_q[NUM_STAGES-1].bad;

  // An accepted word occupies the input stage on the next edge.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> valid_q[ST_IN])
    else $error("accepted word did not enter the pipeline");

  // A held output word keeps its result.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed under stall");

  // A negative inverse radicand always raises the flag and yields zero.
  a_negrad_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && pipe_q[NUM_STAGES-1].op && pipe_q[NUM_STAGES-1].neg_rad
      |-> m_axis_tuser && (m_axis_tdata[32:17] == 16'd0))
    else $error("negative radicand not flagged");

  // An inverse conversion with zero spacing is always flagged with x zero.
  a_zero_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && pipe_q[NUM_STAGES-1].op && pipe_q[NUM_STAGES-1].dz
      |-> m_axis_tuser && (m_axis_tdata[16:0] == 17'd0))
    else $error("zero spacing not flagged");

endmodule

[sim/two_cord_plotter_kinematics_test.sv]
// Self-checking testbench of the two-cord plotter kinematics converter.
module two_cord_plotter_kinematics_test;
  import tcpk_pkg::*;

  typedef struct {
    logic [16:0] first;
    logic [15:0] second;
    logic        invalid;
  } coord_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  coord_result_t pending_coords[$];
  logic [15:0]   spacing_copy;
  int            error_count;
  int            hold_left;
  bit            steady_in;
  bit            steady_out;

  two_cord_plotter_kinematics u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Truncating integer square root, one result bit per pass.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r    = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned clamp_len(longint unsigned v, ref logic bad);
    if (v > 65535) begin
      bad = 1'b1;
      return 65535;
    end
    return v;
  endfunction

  // Expected cord lengths or pen position for one word.
  function automatic coord_result_t convert_coords(logic op, logic signed [16:0] fi,
                                                   logic [15:0] si, logic [15:0] sp);
    coord_result_t   res;
    longint          a;
    longint          b;
    longint          d;
    longint          num;
    longint          q;
    longint          r1;
    longint unsigned ax;
    longint unsigned adx;
    longint unsigned aq;
    longint unsigned r2;
    logic            bad;
    a   = fi;
    b   = si;
    d   = sp;
    bad = 1'b0;
    ax  = (a < 0) ? -a : a;
    if (op == OP_FORWARD) begin
      adx = (d - a < 0) ? a - d : d - a;
      r1  = clamp_len(floor_root(ax * ax + b * b), bad);
      r2  = clamp_len(floor_root(adx * adx + b * b), bad);
    end else if (d == 0) begin
      bad = 1'b1;
      r1  = 0;
      r2  = clamp_len(ax, bad);
    end else begin
      num = d * d + a * a - b * b;
      q   = num / (2 * d);
      aq  = (q < 0) ? -q : q;
      if (q > 32767) begin
        r1  = 32767;
        bad = 1'b1;
      end else if (q < -32768) begin
        r1  = -32768;
        bad = 1'b1;
      end else begin
        r1 = q;
      end
      if (aq > ax) begin
        r2  = 0;
        bad = 1'b1;
      end else begin
        r2 = clamp_len(floor_root(ax * ax - aq * aq), bad);
      end
    end
    res.first   = r1[16:0];
    res.second  = r2[15:0];
    res.invalid = bad;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // Register writes and accepted words update the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) spacing_copy = cfg_data_i;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_coords.push_back(convert_coords(s_axis_tuser, s_axis_tdata[16:0],
                                              s_axis_tdata[32:17], spacing_copy));
  end

  // Compare each delivered word with the oldest expectation.
  always @(posedge clk_i) begin
    coord_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_coords.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 0);
      end else begin
        want = pending_coords.pop_front();
        if (m_axis_tdata[16:0] !== want.first)
          report_mismatch("first_out", m_axis_tdata[16:0], want.first);
        if (m_axis_tdata[32:17] !== want.second)
          report_mismatch("second_out", m_axis_tdata[32:17], want.second);
        if (m_axis_tuser !== want.invalid)
          report_mismatch("invalid", m_axis_tuser, want.invalid);
        if (m_axis_tdata[39:33] !== 7'd0)
          report_mismatch("padding", m_axis_tdata[39:33], 0);
      end
    end
  end

  // Receiver: random back-pressure, or a counted hold-off.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = steady_out ? 1'b1 : ($urandom_range(99) >= 24);
    end
  end

  // Each cycle the sender idles with a chance of about one in four.
  task automatic send_word(logic op, logic [16:0] fi, logic [15:0] si);
    @(negedge clk_i);
    while (!steady_in && $urandom_range(99) < 24) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {7'd0, si, fi};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_words();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (pending_coords.size() == 0);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_spacing(logic [15:0] sp);
    drain_words();
    cfg_valid_i = 1'b1;
    cfg_data_i  = sp;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly plausible geometry near the anchors, the rest full-range noise.
  task automatic send_random(int count, logic [15:0] sp);
    logic [16:0] fi;
    logic [15:0] si;
    logic        op;
    for (int i = 0; i < count; i++) begin
      op = 1'($urandom_range(1));
      if ($urandom_range(99) < 70) begin
        fi = 17'($urandom_range(0, 32'(sp) + 200));
        si = 16'($urandom_range(0, 32'(sp) + 200));
        if (op == OP_FORWARD && $urandom_range(3) == 0) fi = -fi;
      end else begin
        fi = 17'($urandom);
        si = 16'($urandom);
      end
      send_word(op, fi, si);
    end
  endtask

  task automatic test_directed();
    send_word(OP_FORWARD, 17'd0, 16'd0);
    send_word(OP_FORWARD, 17'h10000, 16'hFFFF);
    send_word(OP_FORWARD, 17'h0FFFF, 16'hFFFF);
    send_word(OP_FORWARD, 17'h18000, 16'd0);
    send_word(OP_FORWARD, 17'd800, 16'd600);
    send_word(OP_FORWARD, 17'h1FFFF, 16'd1);
    send_word(OP_INVERSE, 17'd1000, 16'd1000);
    send_word(OP_INVERSE, 17'h1FC18, 16'd1000);
    send_word(OP_INVERSE, 17'd100, 16'd3000);
    send_word(OP_INVERSE, 17'd3000, 16'd100);
    send_word(OP_INVERSE, 17'h0FFFF, 16'd0);
    send_word(OP_INVERSE, 17'h10000, 16'hFFFF);
    send_word(OP_INVERSE, 17'd0, 16'hFFFF);
    send_word(OP_INVERSE, 17'd0, 16'd0);
  endtask

  task automatic test_spacing_extremes();
    write_spacing(16'd0);
    send_word(OP_INVERSE, 17'h10000, 16'd5);
    send_word(OP_INVERSE, 17'd1234, 16'hFFFF);
    send_word(OP_FORWARD, 17'd77, 16'd88);
    send_random(60, 16'd64);
    write_spacing(16'd16);
    send_random(200, 16'd16);
    write_spacing(16'hFFFF);
    send_word(OP_INVERSE, 17'h0FFFF, 16'd0);
    send_word(OP_FORWARD, 17'h10000, 16'hFFFF);
    send_random(200, 16'hFFFF);
  endtask

  task automatic test_backpressure();
    write_spacing(16'd4000);
    hold_left = 300;
    send_random(150, 16'd4000);
    drain_words();
    send_random(150, 16'd4000);
  endtask

  task automatic test_random_settings();
    logic [15:0] sp;
    steady_in  = 1'b1;
    steady_out = 1'b1;
    send_random(150, 16'd1600);
    steady_in  = 1'b0;
    steady_out = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sp = 16'($urandom_range(16, 65535));
      write_spacing(sp);
      send_random(150, sp);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_FORWARD;
    m_axis_tready = 1'b0;
    spacing_copy  = 16'd1600;
    error_count   = 0;
    hold_left     = 0;
    steady_in     = 1'b0;
    steady_out    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_spacing_extremes();
    test_backpressure();
    test_random_settings();
    drain_words();

    if (error_count == 0) begin
      $display("two_cord_plotter_kinematics test passed");
    end else begin
      $display("two_cord_plotter_kinematics test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("two_cord_plotter_kinematics test failed");
    $finish;
  end

endmodule

[filelist.f]
src/tcpk_pkg.sv
src/two_cord_plotter_kinematics.sv
sim/two_cord_plotter_kinematics_test.sv
